// File: design/nrr_pkg.sv
// ----------------------------------------------------------------------------
// Round robin router package
// Shared sizes, codes and record types of the round robin router.
// ----------------------------------------------------------------------------
package nrr_pkg;

  localparam int NUM_INPUTS   = 4;
  localparam int NUM_OUTPUTS  = 4;
  localparam int NUM_TARGETS  = 16;
  localparam int PAYLOAD_BITS = 32;

  localparam int PORT_W   = 2;
  localparam int TGT_W    = 4;
  localparam int ACT_W    = 3;
  localparam int ROUTE_W  = 2 * NUM_TARGETS;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_TABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_INPUTS = 2'd1;

  localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(NUM_INPUTS);

  typedef enum logic {
    OP_ARRIVAL = 1'b0,
    OP_STEP    = 1'b1
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ARRIVAL = 2'd0,
    KIND_FWD     = 2'd1,
    KIND_NONE    = 2'd2
  } kind_t;

  // One classified item as it waits between the front and the back.
  typedef struct packed {
    op_t                     op;
    logic [PORT_W-1:0]       in_port;
    logic [TGT_W-1:0]        target;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    is_forward;
    logic [NUM_OUTPUTS-1:0]  out_ready;
    logic [PORT_W-1:0]       dest_port;
    logic                    port_ok;
  } cmd_t;

  // Contents of one input buffer slot.
  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] payload;
    logic [TGT_W-1:0]        target;
    logic                    dir;
  } flit_t;

  typedef struct packed {
    kind_t                   kind;
    logic                    accepted;
    logic [PORT_W-1:0]       out_port;
    logic [PORT_W-1:0]       src_port;
    logic [TGT_W-1:0]        dest_target;
    logic [PAYLOAD_BITS-1:0] data_out;
    logic                    forward_dir;
    logic                    last;
  } result_t;

  // Queue occupancy seen by the front.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: design/nrr_in_if.sv
// ----------------------------------------------------------------------------
// Router input channel
// Valid/ready channel carrying arrival and step items.
// ----------------------------------------------------------------------------
interface nrr_in_if;
  logic                            valid;
  logic                            ready;
  logic                            op;
  logic [nrr_pkg::PORT_W-1:0]      in_port;
  logic [nrr_pkg::TGT_W-1:0]       target;
  logic [nrr_pkg::PAYLOAD_BITS-1:0] payload;
  logic                            is_forward;
  logic [nrr_pkg::NUM_OUTPUTS-1:0] out_ready;

  modport source (output valid, op, in_port, target, payload, is_forward, out_ready,
                  input ready);
  modport sink   (input valid, op, in_port, target, payload, is_forward, out_ready,
                  output ready);
endinterface

// File: design/nrr_out_if.sv
// ----------------------------------------------------------------------------
// Router result channel
// Valid/ready channel carrying one result item per transfer.
// ----------------------------------------------------------------------------
interface nrr_out_if;
  logic                             valid;
  logic                             ready;
  logic [nrr_pkg::KIND_W-1:0]       kind;
  logic                             accepted;
  logic [nrr_pkg::PORT_W-1:0]       out_port;
  logic [nrr_pkg::PORT_W-1:0]       src_port;
  logic [nrr_pkg::TGT_W-1:0]        dest_target;
  logic [nrr_pkg::PAYLOAD_BITS-1:0] data_out;
  logic                             forward_dir;
  logic                             last;

  modport source (output valid, kind, accepted, out_port, src_port, dest_target,
                  data_out, forward_dir, last, input ready);
  modport sink   (input valid, kind, accepted, out_port, src_port, dest_target,
                  data_out, forward_dir, last, output ready);
endinterface

// File: design/nrr_cfg_if.sv
// ----------------------------------------------------------------------------
// Router configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface nrr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [nrr_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [nrr_pkg::ROUTE_W-1:0]     wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// File: design/nrr_front.sv
// ----------------------------------------------------------------------------
// Router front end
// Accepts items, resolves route and port activity, and pushes them queued.
// ----------------------------------------------------------------------------
module nrr_front (
  nrr_in_if.sink                     in_ch,
  input  logic [nrr_pkg::ROUTE_W-1:0] route_table,
  input  logic [nrr_pkg::ACT_W-1:0]   act_eff,
  input  nrr_pkg::q_status_t          q_status,
  output logic                        push,
  output nrr_pkg::cmd_t               push_cmd
);
  import nrr_pkg::*;

  logic [TGT_W-1:0] tgt_idx;

  assign in_ch.ready = !q_status.full;
  assign push        = in_ch.valid && !q_status.full;

  // Sixteen targets: the four target bits index the table directly.
  assign tgt_idx = in_ch.target;

  always_comb begin
    push_cmd            = '0;
    push_cmd.op         = op_t'(in_ch.op);
    push_cmd.in_port    = in_ch.in_port;
    push_cmd.target     = in_ch.target;
    push_cmd.payload    = in_ch.payload;
    push_cmd.is_forward = in_ch.is_forward;
    push_cmd.out_ready  = in_ch.out_ready;
    push_cmd.dest_port  = route_table[{tgt_idx, 1'b0} +: PORT_W];
    push_cmd.port_ok    = ({1'b0, in_ch.in_port} < act_eff);
  end

endmodule

// File: design/nrr_queue.sv
// ----------------------------------------------------------------------------
// Router command queue
// Short register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module nrr_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  nrr_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output logic               head_valid,
  output nrr_pkg::cmd_t      head,
  output nrr_pkg::q_status_t q_status
);
  import nrr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign q_status.full  = (count_r == CNT_W'(DEPTH));
  assign q_status.empty = (count_r == '0);
  assign head_valid     = !q_status.empty;
  assign head           = mem_r[rd_ptr_r];

  assign do_push = push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_count_up : assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("queue count did not follow a push");

  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("back end popped an empty queue");

endmodule

// File: design/nrr_back.sv
// ----------------------------------------------------------------------------
// Router back end
// Holds the input slots and pointers, arbitrates and emits result items.
// ----------------------------------------------------------------------------
module nrr_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [nrr_pkg::ACT_W-1:0] act_eff,
  input  logic                      head_valid,
  input  nrr_pkg::cmd_t             head,
  output logic                      pop,
  nrr_out_if.source                 out_ch
);
  import nrr_pkg::*;

  logic [NUM_INPUTS-1:0]  full_r, full_nxt;
  flit_t                  slot_r [NUM_INPUTS];
  logic [PORT_W-1:0]      dest_r [NUM_INPUTS];
  logic [PORT_W-1:0]      ptr_r  [NUM_OUTPUTS];
  logic                   step_busy_r, step_busy_nxt;
  logic [NUM_OUTPUTS-1:0] rem_r, rem_nxt;
  logic                   out_valid_r, out_valid_nxt;
  result_t                res_r, res_nxt;

  logic [NUM_OUTPUTS-1:0] gnt_vld;
  logic [PORT_W-1:0]      gnt_src [NUM_OUTPUTS];
  logic [NUM_OUTPUTS-1:0] mask;
  logic [NUM_OUTPUTS-1:0] avail;
  logic [NUM_OUTPUTS-1:0] sel_hot;
  logic [PORT_W-1:0]      sel_out;
  logic [PORT_W-1:0]      sel_src;
  logic                   more;
  logic                   can_emit;
  logic                   arr_ok;
  logic                   load_slot;
  logic                   ptr_we;
  logic [PORT_W-1:0]      ptr_wval;
  logic                   emit_fwd;

  function automatic logic [PORT_W-1:0] rr_mod(input logic [PORT_W-1:0] v,
                                               input logic [ACT_W-1:0]  m);
    logic [ACT_W-1:0] r;
    r = {1'b0, v};
    for (int k = 0; k < NUM_INPUTS; k++) begin
      if (r >= m) begin
        r = r - m;
      end
    end
    return r[PORT_W-1:0];
  endfunction

  // Per output port round robin: the first full, active slot routed here,
  // scanning upward from the pointer. Outputs never compete for a slot.
  always_comb begin
    logic [PORT_W-1:0] start;
    logic [PORT_W-1:0] p;
    for (int o = 0; o < NUM_OUTPUTS; o++) begin
      start      = rr_mod(ptr_r[o], act_eff);
      gnt_vld[o] = 1'b0;
      gnt_src[o] = '0;
      for (int i = NUM_INPUTS - 1; i >= 0; i--) begin
        p = start + PORT_W'(i);
        if (full_r[p] && (dest_r[p] == PORT_W'(o)) && ({1'b0, p} < act_eff)) begin
          gnt_vld[o] = 1'b1;
          gnt_src[o] = p;
        end
      end
    end
  end

  assign mask  = step_busy_r ? rem_r : head.out_ready;
  assign avail = mask & gnt_vld;

  always_comb begin
    sel_out = '0;
    for (int o = NUM_OUTPUTS - 1; o >= 0; o--) begin
      if (avail[o]) begin
        sel_out = PORT_W'(o);
      end
    end
  end

  assign sel_hot  = NUM_OUTPUTS'(1) << sel_out;
  assign sel_src  = gnt_src[sel_out];
  assign more     = |(avail & ~sel_hot);
  assign can_emit = !out_valid_r || out_ch.ready;
  assign arr_ok   = head.port_ok && !full_r[head.in_port];
  assign ptr_wval = ({1'b0, sel_src} + ACT_W'(1) == act_eff) ? '0 : sel_src + PORT_W'(1);

  always_comb begin
    full_nxt      = full_r;
    step_busy_nxt = step_busy_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    res_nxt       = res_r;
    pop           = 1'b0;
    load_slot     = 1'b0;
    ptr_we        = 1'b0;
    emit_fwd      = 1'b0;
    if (head_valid && can_emit) begin
      out_valid_nxt = 1'b1;
      res_nxt       = '0;
      case (head.op)
        OP_ARRIVAL: begin
          res_nxt.kind     = KIND_ARRIVAL;
          res_nxt.accepted = arr_ok;
          res_nxt.last     = 1'b1;
          pop              = 1'b1;
          if (arr_ok) begin
            full_nxt[head.in_port] = 1'b1;
            load_slot              = 1'b1;
          end
        end
        OP_STEP: begin
          if (avail == '0) begin
            res_nxt.kind  = KIND_NONE;
            res_nxt.last  = 1'b1;
            pop           = 1'b1;
            step_busy_nxt = 1'b0;
          end else begin
            emit_fwd            = 1'b1;
            res_nxt.kind        = KIND_FWD;
            res_nxt.out_port    = sel_out;
            res_nxt.src_port    = sel_src;
            res_nxt.dest_target = slot_r[sel_src].target;
            res_nxt.data_out    = slot_r[sel_src].payload;
            res_nxt.forward_dir = slot_r[sel_src].dir;
            res_nxt.last        = !more;
            full_nxt[sel_src]   = 1'b0;
            ptr_we              = 1'b1;
            rem_nxt             = mask & ~sel_hot;
            step_busy_nxt       = more;
            pop                 = !more;
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r      <= '0;
      step_busy_r <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
      for (int o = 0; o < NUM_OUTPUTS; o++) begin
        ptr_r[o] <= '0;
      end
    end else begin
      full_r      <= full_nxt;
      step_busy_r <= step_busy_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
      if (ptr_we) begin
        ptr_r[sel_out] <= ptr_wval;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (load_slot) begin
      slot_r[head.in_port].payload <= head.payload;
      slot_r[head.in_port].target  <= head.target;
      slot_r[head.in_port].dir     <= head.is_forward;
      dest_r[head.in_port]         <= head.dest_port;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = res_r.kind;
  assign out_ch.accepted    = res_r.accepted;
  assign out_ch.out_port    = res_r.out_port;
  assign out_ch.src_port    = res_r.src_port;
  assign out_ch.dest_target = res_r.dest_target;
  assign out_ch.data_out    = res_r.data_out;
  assign out_ch.forward_dir = res_r.forward_dir;
  assign out_ch.last        = res_r.last;

  a_fwd_from_full : assert property (@(posedge clk) disable iff (!rst_n)
    emit_fwd |-> full_r[sel_src] && ({1'b0, sel_src} < act_eff))
    else $error("flit forwarded from an empty or inactive slot");

  a_fwd_frees_slot : assert property (@(posedge clk) disable iff (!rst_n)
    emit_fwd |=> !full_r[$past(sel_src)])
    else $error("forwarded slot still marked full");

  a_busy_on_step : assert property (@(posedge clk) disable iff (!rst_n)
    step_busy_r |-> head_valid && (head.op == OP_STEP))
    else $error("step in progress without a step item at the queue head");

  a_none_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.kind == KIND_NONE || res_r.kind == KIND_ARRIVAL) |-> res_r.last)
    else $error("single result item without last");

endmodule

// File: design/noc_router_round_robin.sv
// ----------------------------------------------------------------------------
// Round robin crossbar router
// Four input slots, four output ports, per output round robin arbitration.
// ----------------------------------------------------------------------------
// The router takes one item per cycle on in_ch whenever its two-entry command
// queue has room. An arrival item (op 0) offers a flit on one input port; it
// is buffered when that port's single slot is empty and the port is below
// active_inputs, and its output port is looked up in route_table (two bits
// per target). A step item (op 1) carries a ready mask of the output ports.
// Each ready output, in ascending order, serves the first waiting flit routed
// to it, scanning the active inputs round robin from its pointer, then moves
// its pointer just past the winner. Every arrival yields exactly one result
// item; a step yields one forwarded flit per served output (up to four), or
// a single "nothing sent" item, and the final result of each item has last
// set. The result channel moves one item per cycle from an output register
// while out_ch is ready; an arrival yields one result and a step one per
// served output on that single port. The front end keeps accepting into the
// queue as the back end drains; back-to-back arrivals run at that rate too.
// Configuration is taken at any time through cfg_ch (always ready) but must
// only be written while the router is idle. An active_inputs value of zero
// acts as one, and values above four act as four.
// ----------------------------------------------------------------------------
module noc_router_round_robin #(
  parameter int QUEUE_DEPTH = 2
) (
  input logic       clk,
  input logic       rst_n,
  nrr_in_if.sink    in_ch,
  nrr_out_if.source out_ch,
  nrr_cfg_if.sink   cfg_ch
);
  import nrr_pkg::*;

  // Configuration registers.
  logic [ROUTE_W-1:0] route_table_r;
  logic [ACT_W-1:0]   active_inputs_r;
  logic [ACT_W-1:0]   act_eff;

  // Front to queue and queue to back.
  logic      push;
  cmd_t      push_cmd;
  q_status_t q_status;
  logic      head_valid;
  cmd_t      head;
  logic      pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_table_r   <= '0;
      active_inputs_r <= ACTIVE_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        CFG_ROUTE_TABLE:   route_table_r   <= cfg_ch.wdata;
        CFG_ACTIVE_INPUTS: active_inputs_r <= cfg_ch.wdata[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the round robin modulus into 1..NUM_INPUTS.
  always_comb begin
    if (active_inputs_r == '0) begin
      act_eff = ACT_W'(1);
    end else if (active_inputs_r > ACT_W'(NUM_INPUTS)) begin
      act_eff = ACT_W'(NUM_INPUTS);
    end else begin
      act_eff = active_inputs_r;
    end
  end

  nrr_front u_front (
    .in_ch       (in_ch),
    .route_table (route_table_r),
    .act_eff     (act_eff),
    .q_status    (q_status),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  nrr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .q_status   (q_status)
  );

  nrr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .act_eff    (act_eff),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
